>>> src/i2cm_pkg.sv
// Types and constants shared by the I2C master bit engine.
// No dependencies; imported by i2cm_front, i2cm_back and the top level.
package i2cm_pkg;

   // Command classes, one for each value of the kind field
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_RESTART = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_WRITE   = 3'd4,
      CMD_READ    = 3'd5,
      CMD_ACK     = 3'd6,
      CMD_NACK    = 3'd7
   } cmd_type;

   // Bus engine phases
   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_START_HI   = 4'd1,
      PH_START_LO   = 4'd2,
      PH_SCL_LO     = 4'd3,
      PH_SDA_SET    = 4'd4,
      PH_SCL_HI     = 4'd5,
      PH_SDA_END    = 4'd6,
      PH_WR_SCL_LO  = 4'd7,
      PH_WR_SDA     = 4'd8,
      PH_WR_SCL_HI  = 4'd9,
      PH_ACK_REL    = 4'd10,
      PH_ACK_SCL_HI = 4'd11,
      PH_RD_SCL_LO  = 4'd12,
      PH_RD_SCL_HI  = 4'd13,
      PH_RD_SAMPLE  = 4'd14
   } phase_type;

   // Variant held in the bit index for the short control sequences
   localparam logic [3:0] VAR_RESTART = 4'd0;
   localparam logic [3:0] VAR_STOP    = 4'd1;
   localparam logic [3:0] VAR_ACK     = 4'd2;
   localparam logic [3:0] VAR_NACK    = 4'd3;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

   // One classified word in the queue between front and back
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] wdata;
      logic       sda;
   } item_type;

endpackage

>>> src/i2c_master_bit_engine_unit.sv
// I2C master bit engine: SCL/SDA sequencer for start, repeated start, stop,
// byte write, byte read, ACK and NACK. Uses i2cm_pkg, i2cm_front, i2cm_back.
//
// Each request word is one tick of the bus timer and carries the kind of
// command (zero for none), the byte to write and the sampled SDA level.
// Every request word yields exactly one response word with the SCL and SDA
// drive, busy and done flags, the last read byte and the last ACK slot level.
// A command is taken only while the engine is idle; otherwise it is ignored.
// Bit timing is set by the half period register on the csr port; the user
// must write it only while no words are in flight, which the block itself
// does not enforce. Reset value is 250 ticks. A request is first written
// into the front queue; the back end then pops it, runs its tick and
// registers the response word. Throughput is one word per cycle while the
// response is not stalled, set by the phase/tick update of the back end.
// Reset empties the queue, drops any pending response and puts the engine
// idle with SCL and SDA released. When rsp_ready is low the response holds;
// the queue keeps accepting until QUEUE_DEPTH words are waiting.
module i2c_master_bit_engine_unit
   import i2cm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nack_seen,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   i2cm_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   i2cm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl_out   (rsp_scl_out),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_read_data (rsp_read_data),
      .rsp_nack_seen (rsp_nack_seen)
   );

endmodule

>>> src/i2cm_front.sv
// Front end of the I2C master bit engine: takes request words, classifies
// the kind field and queues the words for the back end. Uses i2cm_pkg.
module i2cm_front
   import i2cm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_write_data,
   input  logic       req_sda_in,
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   item_type               queue_mem [QUEUE_DEPTH];
   logic     [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic     [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic     [CNT_W-1:0]   count_ff, count_in;
   item_type               item_new;
   logic                   push;
   logic                   pop;

   always_comb begin
      item_new.wdata = req_write_data;
      item_new.sda   = req_sda_in;
      unique case (req_kind)
         CMD_START:   item_new.cmd = CMD_START;
         CMD_RESTART: item_new.cmd = CMD_RESTART;
         CMD_STOP:    item_new.cmd = CMD_STOP;
         CMD_WRITE:   item_new.cmd = CMD_WRITE;
         CMD_READ:    item_new.cmd = CMD_READ;
         CMD_ACK:     item_new.cmd = CMD_ACK;
         CMD_NACK:    item_new.cmd = CMD_NACK;
         default:     item_new.cmd = CMD_NONE;
      endcase
   end

   assign req_ready = (count_ff != CNT_FULL);
   assign q_valid   = (count_ff != '0);
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;
   assign q_item    = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= item_new;
      end
   end

endmodule

>>> src/i2cm_back.sv
// Back end of the I2C master bit engine: runs the bus phase sequencer one
// tick per queued word and holds the response word. Uses i2cm_pkg.
module i2cm_back
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nack_seen
);

   logic [15:0] half_period_ff;
   phase_type   phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_idx_ff, bit_idx_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        ack_ff, ack_in;
   logic [7:0]  rx_hold_ff, rx_hold_in;
   logic        done;

   logic [15:0] full_wait;
   logic [15:0] half_wait;
   logic [15:0] short_wait;
   logic [15:0] tick_dec;
   logic        do_enter;
   phase_type   enter_ph;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        scl_out_ff, sda_out_ff, busy_ff, done_ff, nack_ff;
   logic [7:0]  rdata_ff;

   // zero half period counts as one tick; short delay is never below one
   assign full_wait  = (half_period_ff == '0) ? 16'd1 : half_period_ff;
   assign half_wait  = full_wait >> 1;
   assign short_wait = (half_wait == '0) ? 16'd1 : half_wait;
   assign tick_dec   = (tick_ff != '0) ? tick_ff - 16'd1 : '0;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_idx_in = bit_idx_ff;
      shift_in   = shift_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      ack_in     = ack_ff;
      rx_hold_in = rx_hold_ff;
      done       = 1'b0;
      do_enter   = 1'b0;
      enter_ph   = PH_IDLE;

      if (q_pop) begin
         if (phase_ff == PH_IDLE) begin
            unique case (q_item.cmd)
               CMD_START: begin
                  bit_idx_in = '0;
                  do_enter   = 1'b1;
                  enter_ph   = PH_START_HI;
               end
               CMD_RESTART: begin
                  bit_idx_in = VAR_RESTART;
                  do_enter   = 1'b1;
                  enter_ph   = PH_SCL_LO;
               end
               CMD_STOP: begin
                  bit_idx_in = VAR_STOP;
                  do_enter   = 1'b1;
                  enter_ph   = PH_SCL_LO;
               end
               CMD_WRITE: begin
                  bit_idx_in = '0;
                  shift_in   = q_item.wdata;
                  do_enter   = 1'b1;
                  enter_ph   = PH_WR_SCL_LO;
               end
               CMD_READ: begin
                  bit_idx_in = '0;
                  shift_in   = '0;
                  do_enter   = 1'b1;
                  enter_ph   = PH_RD_SCL_LO;
               end
               CMD_ACK: begin
                  bit_idx_in = VAR_ACK;
                  do_enter   = 1'b1;
                  enter_ph   = PH_SCL_LO;
               end
               CMD_NACK: begin
                  bit_idx_in = VAR_NACK;
                  do_enter   = 1'b1;
                  enter_ph   = PH_SCL_LO;
               end
               default: ;
            endcase
         end else begin
            tick_in = tick_dec;
            if (tick_dec == '0) begin
               // hold ran out: pick the next phase, idle means finished
               unique case (phase_ff)
                  PH_START_HI:  enter_ph = PH_START_LO;
                  PH_SCL_LO:    enter_ph = PH_SDA_SET;
                  PH_SDA_SET:   enter_ph = PH_SCL_HI;
                  PH_SCL_HI: begin
                     enter_ph = (bit_idx_ff >= VAR_ACK) ? PH_IDLE : PH_SDA_END;
                  end
                  PH_WR_SCL_LO: enter_ph = PH_WR_SDA;
                  PH_WR_SDA:    enter_ph = PH_WR_SCL_HI;
                  PH_WR_SCL_HI: begin
                     shift_in   = {shift_ff[6:0], 1'b0};
                     bit_idx_in = bit_idx_ff + 4'd1;
                     enter_ph   = bit_idx_in[3] ? PH_ACK_REL : PH_WR_SCL_LO;
                  end
                  PH_ACK_REL:   enter_ph = PH_ACK_SCL_HI;
                  PH_ACK_SCL_HI: begin
                     ack_in = q_item.sda;
                  end
                  PH_RD_SCL_LO: enter_ph = PH_RD_SCL_HI;
                  PH_RD_SCL_HI: enter_ph = PH_RD_SAMPLE;
                  PH_RD_SAMPLE: begin
                     bit_idx_in = bit_idx_ff + 4'd1;
                     if (bit_idx_in[3]) begin
                        rx_hold_in = shift_ff;
                     end else begin
                        enter_ph = PH_RD_SCL_LO;
                     end
                  end
                  default: ;
               endcase
               if (enter_ph == PH_IDLE) begin
                  phase_in   = PH_IDLE;
                  bit_idx_in = '0;
                  tick_in    = '0;
                  done       = 1'b1;
               end else begin
                  do_enter = 1'b1;
               end
            end
         end

         if (do_enter) begin
            phase_in = enter_ph;
            unique case (enter_ph)
               PH_START_HI: begin
                  scl_in  = 1'b1;
                  sda_in  = 1'b1;
                  tick_in = full_wait;
               end
               PH_START_LO: begin
                  sda_in  = 1'b0;
                  tick_in = full_wait;
               end
               PH_SCL_LO: begin
                  scl_in  = 1'b0;
                  tick_in = short_wait;
               end
               PH_SDA_SET: begin
                  sda_in  = (bit_idx_in == VAR_RESTART) || (bit_idx_in == VAR_NACK);
                  tick_in = short_wait;
               end
               PH_SCL_HI: begin
                  scl_in  = 1'b1;
                  tick_in = (bit_idx_in == VAR_NACK) ? full_wait : short_wait;
               end
               PH_SDA_END: begin
                  sda_in  = (bit_idx_in == VAR_STOP);
                  tick_in = short_wait;
               end
               PH_WR_SCL_LO: begin
                  scl_in  = 1'b0;
                  tick_in = full_wait;
               end
               PH_WR_SDA: begin
                  sda_in  = shift_in[7];
                  tick_in = short_wait;
               end
               PH_WR_SCL_HI, PH_ACK_SCL_HI: begin
                  scl_in  = 1'b1;
                  tick_in = full_wait;
               end
               PH_ACK_REL: begin
                  scl_in  = 1'b0;
                  sda_in  = 1'b1;
                  tick_in = short_wait;
               end
               PH_RD_SCL_LO: begin
                  scl_in  = 1'b0;
                  sda_in  = 1'b1;
                  tick_in = full_wait;
               end
               PH_RD_SCL_HI: begin
                  scl_in  = 1'b1;
                  tick_in = short_wait;
               end
               PH_RD_SAMPLE: begin
                  shift_in = {shift_in[6:0], q_item.sda};
                  tick_in  = full_wait;
               end
               default: tick_in = 16'd1;
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         phase_ff       <= PH_IDLE;
         tick_ff        <= '0;
         bit_idx_ff     <= '0;
         shift_ff       <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         ack_ff         <= 1'b0;
         rx_hold_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            half_period_ff <= csr_wr_data;
         end
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_idx_ff   <= bit_idx_in;
         shift_ff     <= shift_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         ack_ff       <= ack_in;
         rx_hold_ff   <= rx_hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response word holding register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         scl_out_ff <= scl_in;
         sda_out_ff <= sda_in;
         busy_ff    <= (phase_in != PH_IDLE);
         done_ff    <= done;
         rdata_ff   <= rx_hold_in;
         nack_ff    <= ack_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_out   = scl_out_ff;
   assign rsp_sda_out   = sda_out_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_nack_seen = nack_ff;

endmodule

>>> src/i2cm_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends only on the top level's ports.
module i2cm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_scl_out,
   input logic        rsp_sda_out,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_nack_seen
);

   // stalled response word must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl_out)
         && $stable(rsp_sda_out) && $stable(rsp_busy_res) && $stable(rsp_done_res)
         && $stable(rsp_read_data) && $stable(rsp_nack_seen))
      else $error("response word changed while stalled");

   // a completing command leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done and busy together");

   // every sequence ends with SCL released
   a_done_scl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_scl_out)
      else $error("command finished with SCL held low");

   // no response word survives reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_i2cm_checker (.*);
